[rtl/miir_pkg.sv]
package miir_pkg;

    // Lane count is fixed by the four named sample and result fields.
    localparam int CHANNELS      = 4;
    localparam int MAX_ORDER_DEF = 5;
    localparam int NTAPS         = 6;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 32;
    localparam int COEF_FRAC   = 24;
    localparam int HIST_W      = 24;
    localparam int HIST_FRAC   = 8;
    localparam int ACC_W       = 60;
    localparam int CFG_DATA_W  = 64;
    localparam int REG_IDX_W   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0_B1 = 3'd0,
        REG_B2_B3 = 3'd1,
        REG_B4_B5 = 3'd2,
        REG_A1_A2 = 3'd3,
        REG_A3_A4 = 3'd4,
        REG_A5    = 3'd5
    } reg_index_t;

    // Shared coefficient set, all signed Q8.24.
    typedef struct packed {
        logic [NTAPS-1:0][COEF_W-1:0] b;
        logic [NTAPS-1:1][COEF_W-1:0] a;
    } coef_set_t;

    // Pipeline control that the top level hands to every lane.
    typedef struct packed {
        logic accept;
        logic s1_move;
        logic s2_move;
        logic s2_valid;
    } lane_ctl_t;

endpackage

[rtl/miir_if.sv]
interface miir_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [miir_pkg::SAMPLE_W-1:0]  sample_ch0;
    logic signed [miir_pkg::SAMPLE_W-1:0]  sample_ch1;
    logic signed [miir_pkg::SAMPLE_W-1:0]  sample_ch2;
    logic signed [miir_pkg::SAMPLE_W-1:0]  sample_ch3;

    modport source (output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                    input ready);
    modport sink   (input valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
                    output ready);
endinterface

interface miir_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [miir_pkg::SAMPLE_W-1:0]  filtered_ch0;
    logic signed [miir_pkg::SAMPLE_W-1:0]  filtered_ch1;
    logic signed [miir_pkg::SAMPLE_W-1:0]  filtered_ch2;
    logic signed [miir_pkg::SAMPLE_W-1:0]  filtered_ch3;

    modport source (output valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
                    input ready);
    modport sink   (input valid, filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3,
                    output ready);
endinterface

[rtl/multichannel_iir_filter.sv]
// Channel    Direction  Payload                                 Accepted when
// samples    in         sample_ch0..sample_ch3, signed 16 bits  valid && ready
// results    out        filtered_ch0..filtered_ch3, signed 16   valid && ready
// cfg        in         cfg_index 3 bits, cfg_wr_data 64 bits   cfg_wr_en
//
// One item is accepted per cycle while samples.ready is high; it passes the
// product, partial sum and output registers, and its result is offered from
// the output register. The rate is set by the last stage of each lane, where
// the newest output feeds the a1 multiplier, the final add and the rounding
// in one combinational path. Reset clears coefficients, histories and all
// valid flags. Each stage advances on its own, so the block keeps accepting
// items while a result waits at the output, until all three stages are full.
module multichannel_iir_filter #(
    parameter int MAX_ORDER = miir_pkg::MAX_ORDER_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    miir_sample_if.sink                      samples,
    miir_result_if.source                    results,
    input  logic                             cfg_wr_en,
    input  logic [miir_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [miir_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int CHANNELS = miir_pkg::CHANNELS;
    localparam int SAMPLE_W = miir_pkg::SAMPLE_W;

    miir_pkg::coef_set_t   coef;
    miir_pkg::lane_ctl_t   ctl;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic s2_free;
    logic s1_free;

    logic signed [SAMPLE_W-1:0] lane_sample   [CHANNELS];
    logic signed [SAMPLE_W-1:0] lane_filtered [CHANNELS];
    logic signed [SAMPLE_W-1:0] filtered_reg  [CHANNELS];

    // The coefficient set is shared by all lanes.
    miir_coef_regs u_coef_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .coef        (coef)
    );

    assign lane_sample[0] = samples.sample_ch0;
    assign lane_sample[1] = samples.sample_ch1;
    assign lane_sample[2] = samples.sample_ch2;
    assign lane_sample[3] = samples.sample_ch3;

    // A stage can take a new item when it is empty or its item moves on in
    // the same cycle. All lanes move in lockstep, so one set of flags serves.
    assign out_free = !out_valid_reg || results.ready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign samples.ready = s1_free;

    assign ctl.accept   = samples.valid && s1_free;
    assign ctl.s1_move  = s1_valid_reg && s2_free;
    assign ctl.s2_move  = s2_valid_reg && out_free;
    assign ctl.s2_valid = s2_valid_reg;

    always_comb
    begin
        s1_valid_next  = ctl.accept  ? 1'b1 : (ctl.s1_move ? 1'b0 : s1_valid_reg);
        s2_valid_next  = ctl.s1_move ? 1'b1 : (ctl.s2_move ? 1'b0 : s2_valid_reg);
        out_valid_next = ctl.s2_move ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    // One filter lane per channel: input history, feedforward products, the
    // partial sum stage and the recursive output stage.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        miir_lane #(
            .MAX_ORDER (MAX_ORDER)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .coef     (coef),
            .ctl      (ctl),
            .sample   (lane_sample[c]),
            .filtered (lane_filtered[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Merging stage: the lane outputs are gathered into one result item.
    always_ff @(posedge clk)
    begin
        if (ctl.s2_move)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                filtered_reg[c] <= lane_filtered[c];
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.filtered_ch0 = filtered_reg[0];
    assign results.filtered_ch1 = filtered_reg[1];
    assign results.filtered_ch2 = filtered_reg[2];
    assign results.filtered_ch3 = filtered_reg[3];

    // An accepted item always lands in the first stage.
    a_accept_fills_s1 : assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.accept |=> s1_valid_reg
    ) else $error("accepted item did not enter the first stage");

    // An item leaving the first stage always lands in the second.
    a_s1_move_fills_s2 : assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.s1_move |=> s2_valid_reg
    ) else $error("item lost between first and second stage");

    // A finished item always reaches the output register.
    a_s2_move_fills_out : assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.s2_move |=> out_valid_reg
    ) else $error("finished item did not reach the output");

    // The block never refuses an item while its first stage is empty.
    a_ready_when_s1_empty : assert property (
        @(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> samples.ready
    ) else $error("input held off with an empty first stage");

endmodule

[rtl/miir_coef_regs.sv]
module miir_coef_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [miir_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [miir_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    output miir_pkg::coef_set_t                  coef
);

    miir_pkg::coef_set_t coef_reg;
    logic [miir_pkg::COEF_W-1:0] lo_word;
    logic [miir_pkg::COEF_W-1:0] hi_word;

    assign lo_word = cfg_wr_data[miir_pkg::COEF_W-1:0];
    assign hi_word = cfg_wr_data[miir_pkg::CFG_DATA_W-1:miir_pkg::COEF_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                miir_pkg::REG_B0_B1:
                begin
                    coef_reg.b[0] <= lo_word;
                    coef_reg.b[1] <= hi_word;
                end
                miir_pkg::REG_B2_B3:
                begin
                    coef_reg.b[2] <= lo_word;
                    coef_reg.b[3] <= hi_word;
                end
                miir_pkg::REG_B4_B5:
                begin
                    coef_reg.b[4] <= lo_word;
                    coef_reg.b[5] <= hi_word;
                end
                miir_pkg::REG_A1_A2:
                begin
                    coef_reg.a[1] <= lo_word;
                    coef_reg.a[2] <= hi_word;
                end
                miir_pkg::REG_A3_A4:
                begin
                    coef_reg.a[3] <= lo_word;
                    coef_reg.a[4] <= hi_word;
                end
                miir_pkg::REG_A5:
                begin
                    coef_reg.a[5] <= lo_word;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign coef = coef_reg;

endmodule

[rtl/miir_lane.sv]
module miir_lane #(
    parameter int MAX_ORDER = miir_pkg::MAX_ORDER_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  miir_pkg::coef_set_t                   coef,
    input  miir_pkg::lane_ctl_t                   ctl,
    input  logic signed [miir_pkg::SAMPLE_W-1:0]  sample,
    output logic signed [miir_pkg::SAMPLE_W-1:0]  filtered
);

    localparam int ACC_W    = miir_pkg::ACC_W;
    localparam int SAMPLE_W = miir_pkg::SAMPLE_W;
    localparam int HIST_W   = miir_pkg::HIST_W;
    localparam int PROD_B_W = miir_pkg::COEF_W + SAMPLE_W;
    localparam int PROD_A_W = miir_pkg::COEF_W + HIST_W;
    localparam logic signed [ACC_W-1:0] ACC_HALF =
        ACC_W'(64'd1 << (miir_pkg::COEF_FRAC - 1));
    localparam logic signed [HIST_W:0] HIST_HALF =
        (HIST_W + 1)'(1 << (miir_pkg::HIST_FRAC - 1));

    // Round half up to Q16.8 and saturate to the history width.
    function automatic logic signed [HIST_W-1:0] round_hist(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] q;
        q = (acc + ACC_HALF) >>> miir_pkg::COEF_FRAC;
        if ((&q[ACC_W-1:HIST_W-1]) || !(|q[ACC_W-1:HIST_W-1]))
            return q[HIST_W-1:0];
        else if (q[ACC_W-1])
            return {1'b1, {(HIST_W-1){1'b0}}};
        else
            return {1'b0, {(HIST_W-1){1'b1}}};
    endfunction

    // Round a Q16.8 value half up to an integer and saturate to 16 bits.
    function automatic logic signed [SAMPLE_W-1:0] round_out(
        input logic signed [HIST_W-1:0] y
    );
        logic signed [HIST_W:0] z;
        z = ($signed({y[HIST_W-1], y}) + HIST_HALF) >>> miir_pkg::HIST_FRAC;
        if ((&z[HIST_W:SAMPLE_W-1]) || !(|z[HIST_W:SAMPLE_W-1]))
            return z[SAMPLE_W-1:0];
        else if (z[HIST_W])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    logic signed [SAMPLE_W-1:0] uh_reg   [MAX_ORDER];
    logic signed [HIST_W-1:0]   yh_reg   [MAX_ORDER];
    logic signed [PROD_B_W-1:0] prod_reg [MAX_ORDER+1];
    logic signed [PROD_B_W-1:0] prod_next[MAX_ORDER+1];
    logic signed [ACC_W-1:0]    part_reg;
    logic signed [ACC_W-1:0]    part_next;
    logic signed [ACC_W-1:0]    ff_sum;
    logic signed [ACC_W-1:0]    fb_sum;
    logic signed [PROD_A_W-1:0] fb_prod  [MAX_ORDER+1];
    logic signed [PROD_A_W-1:0] a1_prod;
    logic signed [ACC_W-1:0]    acc;
    logic signed [HIST_W-1:0]   y_new;

    // Feedforward products for the item being accepted.
    always_comb
    begin
        prod_next[0] = $signed(coef.b[0]) * sample;
        for (int k = 1; k <= MAX_ORDER; k++)
        begin
            prod_next[k] = $signed(coef.b[k]) * uh_reg[k-1];
        end
    end

    // Second stage: feedforward sum and the feedback taps two and up. When the
    // item ahead is still in the last stage, its output is not yet in the
    // history, so the taps read one place closer.
    always_comb
    begin
        ff_sum     = '0;
        fb_sum     = '0;
        fb_prod[0] = '0;
        fb_prod[1] = '0;
        for (int k = 0; k <= MAX_ORDER; k++)
        begin
            ff_sum = ff_sum + ACC_W'(prod_reg[k]);
        end
        for (int k = 2; k <= MAX_ORDER; k++)
        begin
            fb_prod[k] = $signed(coef.a[k]) * (ctl.s2_valid ? yh_reg[k-2] : yh_reg[k-1]);
            fb_sum     = fb_sum + ACC_W'(fb_prod[k]);
        end
        part_next = (ff_sum <<< miir_pkg::HIST_FRAC) - fb_sum;
    end

    // Last stage closes the recursion through the newest output.
    always_comb
    begin
        a1_prod  = $signed(coef.a[1]) * yh_reg[0];
        acc      = part_reg - ACC_W'(a1_prod);
        y_new    = round_hist(acc);
        filtered = round_out(y_new);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                uh_reg[k] <= '0;
                yh_reg[k] <= '0;
            end
        end
        else
        begin
            if (ctl.accept)
            begin
                uh_reg[0] <= sample;
                for (int k = 1; k < MAX_ORDER; k++)
                begin
                    uh_reg[k] <= uh_reg[k-1];
                end
            end
            if (ctl.s2_move)
            begin
                yh_reg[0] <= y_new;
                for (int k = 1; k < MAX_ORDER; k++)
                begin
                    yh_reg[k] <= yh_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            for (int k = 0; k <= MAX_ORDER; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (ctl.s1_move)
        begin
            part_reg <= part_next;
        end
    end

endmodule
